FILE: design/fixed_priority_ready_queue_defines.svh
// Assertion macros for the fixed priority ready queue checker.
`ifndef FIXED_PRIORITY_READY_QUEUE_DEFINES_SVH
`define FIXED_PRIORITY_READY_QUEUE_DEFINES_SVH
// Assert an implication on clk, disabled in reset.
`define FPRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fprq check failed");
// Assert a next-cycle implication on clk, disabled in reset.
`define FPRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fprq check failed");
`endif

FILE: design/fprq_pkg.sv
// Package: types, constants and codes for the fixed priority ready queue.
`timescale 1ns / 1ps
`default_nettype none
package fprq_pkg;
    localparam int NUM_PRIO_DEF  = 32;
    localparam int NUM_TASKS_DEF = 64;
    localparam int TASK_W        = 6;
    localparam int PRIO_W        = 5;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADD_IGN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REM_IGN = 2'd2;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_REM = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_FIND,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: design/fixed_priority_ready_queue.sv
// An accepted transaction passes through read, update, encode and present steps to its result.
// Transactions are taken one at a time; the stored-priority read at capture, the
// head/tail read, the write-back of links and head/tail with the bitmap scan, the output
// load and the idle state after the result leaves all come before the next is accepted.
// Reset clears the bitmap and per-task membership flags; the link, head, tail and
// priority memories stay unwritten and are read only where a flag shows valid data.
`timescale 1ns / 1ps
`default_nettype none
module fixed_priority_ready_queue #(
    parameter int NUM_PRIO  = fprq_pkg::NUM_PRIO_DEF,
    parameter int NUM_TASKS = fprq_pkg::NUM_TASKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic [fprq_pkg::TASK_W-1:0]   task_id,
    input  wire logic [fprq_pkg::PRIO_W-1:0]   priority_req,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [fprq_pkg::STATUS_W-1:0]      status,
    output logic                               ready_valid,
    output logic [fprq_pkg::TASK_W-1:0]        ready_task,
    output logic [fprq_pkg::PRIO_W-1:0]        ready_priority
);
    import fprq_pkg::*;

    localparam int TI_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PI_W = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;

    // Memories: head/tail per priority, links and stored priority per task.
    logic [TASK_W-1:0] head_mem [NUM_PRIO];
    logic [TASK_W-1:0] tail_mem [NUM_PRIO];
    logic [TASK_W-1:0] next_mem [NUM_TASKS];
    logic [TASK_W-1:0] prev_mem [NUM_TASKS];
    logic [PRIO_W-1:0] tprio_mem[NUM_TASKS];

    logic [NUM_PRIO-1:0]  map_reg, map_next;
    logic [NUM_TASKS-1:0] queued_reg, queued_next;

    state_t state_reg, state_next;

    // Captured transaction.
    logic              mode_reg;
    logic [TASK_W-1:0] tid_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              tid_ok;
    logic [TI_W-1:0]   tix;
    logic [TI_W-1:0]   in_tix;
    logic [TI_W-1:0]   rd_tix;
    logic [PI_W-1:0]   pix_add;

    // Registered memory read data.
    logic [TASK_W-1:0] rd_head, rd_tail, rd_next, rd_prev;
    logic [PRIO_W-1:0] rd_tprio;
    logic [PI_W-1:0]   rd_pix;

    // Output register.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rv_reg;
    logic [TASK_W-1:0]   rt_reg;
    logic [PRIO_W-1:0]   rp_reg;

    // Priority scan result.
    logic              found;
    logic [PI_W-1:0]   found_p;
    logic [PI_W-1:0]   op_p;
    logic [TASK_W-1:0] head_rd_found;
    logic [PI_W-1:0]   found_p_pre;
    logic              found_pre;
    logic              found_q;
    logic [PI_W-1:0]   found_p_q;

    // Head write of the write stage, forwarded into the scan's head read.
    logic              head_we;
    logic [TASK_W-1:0] head_wd;

    assign tid_ok = (32'(tid_reg) < 32'(NUM_TASKS));
    assign tix    = tid_ok ? tid_reg[TI_W-1:0] : '0;
    assign in_tix = (32'(task_id) < 32'(NUM_TASKS)) ? task_id[TI_W-1:0] : '0;
    // Address the task memories from the input while idle so the stored priority
    // is ready by the head/tail read.
    assign rd_tix = (state_reg == S_IDLE) ? in_tix : tix;
    // Saturate out-of-range priorities to the lowest level.
    assign pix_add = (32'(prio_reg) < 32'(NUM_PRIO)) ? prio_reg[PI_W-1:0]
                                                      : PI_W'(NUM_PRIO - 1);
    assign rd_pix  = (32'(rd_tprio) < 32'(NUM_PRIO)) ? rd_tprio[PI_W-1:0]
                                                      : PI_W'(NUM_PRIO - 1);
    assign op_p    = (mode_reg == MODE_ADD) ? pix_add : rd_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            map_reg    <= '0;
            queued_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            map_reg    <= map_next;
            queued_reg <= queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg <= mode;
            tid_reg  <= task_id;
            prio_reg <= priority_req;
        end
        // Status is decided before the membership flags advance.
        if (state_reg == S_WRITE)
        begin
            status_reg <= status_next;
        end
        if (state_reg == S_FIND)
        begin
            rv_reg     <= found;
            rt_reg     <= found ? head_rd_found : '0;
            rp_reg     <= found ? PRIO_W'(found_p) : '0;
        end
    end

    // Read stage: task-indexed reads, then head/tail at the operation priority.
    always_ff @(posedge clk)
    begin
        rd_next  <= next_mem[rd_tix];
        rd_prev  <= prev_mem[rd_tix];
        rd_tprio <= tprio_mem[rd_tix];
    end

    // Head/tail are read in the cycle after the task reads, once the stored priority is known.
    always_ff @(posedge clk)
    begin
        rd_head <= head_mem[op_p];
        rd_tail <= tail_mem[op_p];
    end

    always_ff @(posedge clk)
    begin
        if (head_we && found_p_pre == op_p)
        begin
            head_rd_found <= head_wd;
        end
        else
        begin
            head_rd_found <= head_mem[found_p_pre];
        end
    end

    // Bitmap scan feeds the head read during WRITE, ahead of FIND.
    always_comb
    begin
        found_pre   = 1'b0;
        found_p_pre = '0;
        for (int q = NUM_PRIO - 1; q >= 0; q--)
        begin
            if (map_next[q])
            begin
                found_pre   = 1'b1;
                found_p_pre = PI_W'(q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_q   <= found_pre;
        found_p_q <= found_p_pre;
    end
    assign found   = found_q;
    assign found_p = found_p_q;

    // Decisions of the write stage.
    logic add_ok, rem_ok, is_head, is_tail, qne;
    logic [TI_W-1:0] tl_ix, a_ix, b_ix;
    assign qne     = map_reg[op_p];
    assign add_ok  = (mode_reg == MODE_ADD) && tid_ok && !queued_reg[tix];
    assign rem_ok  = (mode_reg == MODE_REM) && tid_ok && queued_reg[tix];
    assign is_head = (rd_head == tid_reg);
    assign is_tail = (rd_tail == tid_reg);
    assign tl_ix   = (32'(rd_tail) < 32'(NUM_TASKS)) ? rd_tail[TI_W-1:0] : '0;
    assign a_ix    = (32'(rd_prev) < 32'(NUM_TASKS)) ? rd_prev[TI_W-1:0] : '0;
    assign b_ix    = (32'(rd_next) < 32'(NUM_TASKS)) ? rd_next[TI_W-1:0] : '0;
    assign head_we = (state_reg == S_WRITE)
                     && ((add_ok && !qne) || (rem_ok && is_head && !is_tail));
    assign head_wd = add_ok ? tid_reg : rd_next;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            if (add_ok)
            begin
                if (qne)
                begin
                    next_mem[tl_ix] <= tid_reg;
                    prev_mem[tix]   <= rd_tail;
                end
                else
                begin
                    head_mem[op_p] <= tid_reg;
                end
                tail_mem[op_p] <= tid_reg;
                tprio_mem[tix] <= PRIO_W'(op_p);
            end
            else if (rem_ok)
            begin
                if (is_head && !is_tail)
                begin
                    head_mem[op_p] <= rd_next;
                end
                else if (is_tail && !is_head)
                begin
                    tail_mem[op_p] <= rd_prev;
                end
                else if (!is_head && !is_tail)
                begin
                    next_mem[a_ix] <= rd_next;
                    prev_mem[b_ix] <= rd_prev;
                end
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        map_next    = map_reg;
        queued_next = queued_reg;
        status_next = ST_OK;
        in_stall    = 1'b1;
        if (mode_reg == MODE_ADD && !add_ok)
        begin
            status_next = ST_ADD_IGN;
        end
        else if (mode_reg == MODE_REM && !rem_ok)
        begin
            status_next = ST_REM_IGN;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // Update bitmap and membership; the scan samples map_next here.
                if (add_ok)
                begin
                    map_next[op_p] = 1'b1;
                    queued_next[tix] = 1'b1;
                end
                else if (rem_ok)
                begin
                    if (is_head && is_tail)
                    begin
                        map_next[op_p] = 1'b0;
                    end
                    queued_next[tix] = 1'b0;
                end
                state_next = S_FIND;
            end
            S_FIND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = (state_reg == S_OUT);
    assign status         = status_reg;
    assign ready_valid    = rv_reg;
    assign ready_task     = rt_reg;
    assign ready_priority = rp_reg;
endmodule
`default_nettype wire

FILE: design/fprq_checker.sv
// Port-level checker for the fixed priority ready queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_priority_ready_queue_defines.svh"
module fprq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] status,
    input wire logic       ready_valid,
    input wire logic [5:0] ready_task,
    input wire logic [4:0] ready_priority
);
    import fprq_pkg::*;
    `FPRQ_ASSERT_IMP(a_idle_report, out_valid && !ready_valid, ready_task == '0 && ready_priority == '0)
    `FPRQ_ASSERT_IMP(a_status_code, out_valid, status <= ST_REM_IGN)
    `FPRQ_ASSERT_IMP(a_one_at_a_time, out_valid, in_stall)
    `FPRQ_ASSERT_NXT(a_accept_then_busy, in_valid && !in_stall, in_stall && !out_valid)
    `FPRQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ready_task))
endmodule
bind fixed_priority_ready_queue fprq_checker u_fprq_checker (.*);
`default_nettype wire

FILE: verif/tb_fixed_priority_ready_queue.sv
// Self-checking testbench for the fixed priority ready queue.
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_priority_ready_queue;
    import fprq_pkg::*;

    localparam int NPRIO      = NUM_PRIO_DEF;
    localparam int NTASK      = NUM_TASKS_DEF;
    localparam int CYCLE_MAX  = 400000;
    localparam int DRAIN_WAIT = 20;
    localparam int HOLDOFF_LEN = 300;

    // One queued operation for the driver.
    typedef struct packed {
        logic              mode;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } op_t;

    // One predicted scheduler answer.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rdy;
        logic [TASK_W-1:0]   rtask;
        logic [PRIO_W-1:0]   rprio;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
    logic out_valid;
    logic out_stall;
    logic [STATUS_W-1:0] status;
    logic ready_valid;
    logic [TASK_W-1:0] ready_task;
    logic [PRIO_W-1:0] ready_priority;

    fixed_priority_ready_queue u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .ready_valid    (ready_valid),
        .ready_task     (ready_task),
        .ready_priority (ready_priority)
    );

    // Shadow scheduler state: per-priority FIFOs held as plain queues.
    logic [TASK_W-1:0] prio_fifo [NPRIO][$];
    logic              shadow_queued [NTASK] = '{default: 1'b0};
    logic [PRIO_W-1:0] shadow_prio [NTASK];

    op_t     pending_ops [$];
    answer_t expected_answers [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  holdoff_cycles;
    bit  holdoff_go;
    bit  holdoff_done;
    bit  send_pause;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one operation to the shadow state and return the answer it yields.
    function automatic answer_t schedule_op(op_t op);
        answer_t ans;
        int p;
        ans = '0;
        if (op.mode == MODE_ADD) begin
            if (op.task_id >= NTASK || shadow_queued[op.task_id]) begin
                ans.status = ST_ADD_IGN;
            end else begin
                p = (op.prio >= NPRIO) ? NPRIO - 1 : op.prio;
                prio_fifo[p].push_back(op.task_id);
                shadow_queued[op.task_id] = 1'b1;
                shadow_prio[op.task_id] = p[PRIO_W-1:0];
                ans.status = ST_OK;
            end
        end else begin
            if (op.task_id >= NTASK || !shadow_queued[op.task_id]) begin
                ans.status = ST_REM_IGN;
            end else begin
                p = shadow_prio[op.task_id];
                for (int i = 0; i < prio_fifo[p].size(); i++) begin
                    if (prio_fifo[p][i] == op.task_id) begin
                        prio_fifo[p].delete(i);
                        break;
                    end
                end
                shadow_queued[op.task_id] = 1'b0;
                ans.status = ST_OK;
            end
        end
        for (int q = 0; q < NPRIO; q++) begin
            if (prio_fifo[q].size() != 0) begin
                ans.rdy = 1'b1;
                ans.rtask = prio_fifo[q][0];
                ans.rprio = q[PRIO_W-1:0];
                break;
            end
        end
        return ans;
    endfunction

    function automatic op_t make_op(logic m, int t, int p);
        op_t op;
        op.mode = m;
        op.task_id = t[TASK_W-1:0];
        op.prio = p[PRIO_W-1:0];
        return op;
    endfunction

    // Driver: advance to the next pending operation once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            mode <= MODE_ADD;
            task_id <= '0;
            priority_req <= '0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                expected_answers.push_back(
                    schedule_op(make_op(mode, task_id, priority_req)));
            end
            // Hold valid low while idling, pausing or out of work.
            if (pending_ops.size() != 0 && !send_pause
                && $urandom_range(99) >= send_idle_pct) begin
                op_t op;
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                mode <= op.mode;
                task_id <= op.task_id;
                priority_req <= op.prio;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off is counted here, apart from the random stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b1;
            holdoff_cycles <= 0;
            holdoff_done <= 1'b0;
        end else if (holdoff_go && !holdoff_done) begin
            holdoff_cycles <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
            out_stall <= 1'b1;
        end else if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: check each accepted answer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: status %0d task %0d",
                             status, ready_task);
            end else begin
                answer_t exp_ans;
                exp_ans = expected_answers.pop_front();
                if (status !== exp_ans.status || ready_valid !== exp_ans.rdy
                    || ready_task !== exp_ans.rtask
                    || ready_priority !== exp_ans.rprio) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st%0d v%0d t%0d p%0d got st%0d v%0d t%0d p%0d",
                                 exp_ans.status, exp_ans.rdy, exp_ans.rtask,
                                 exp_ans.rprio, status, ready_valid, ready_task,
                                 ready_priority);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // Mostly valid traffic: remove tasks that are queued, add ones that are not.
    task automatic queue_random(int n);
        bit live [NTASK];
        int t;
        foreach (live[i]) live[i] = shadow_queued[i];
        for (int i = 0; i < n; i++) begin
            t = $urandom_range(NTASK - 1);
            if ($urandom_range(9) == 0) begin
                pending_ops.push_back(make_op(1'($urandom_range(1)), t, $urandom_range(31)));
            end else begin
                // Bias priorities toward a few levels so FIFOs grow deep.
                pending_ops.push_back(make_op(live[t], t,
                    $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(3)));
                live[t] = !live[t];
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_go = 1'b0;
        send_pause = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty removes, extremes, duplicate add, middle/tail/sole-entry unlink.
        pending_ops.push_back(make_op(MODE_REM, 0, 0));
        pending_ops.push_back(make_op(MODE_ADD, 63, 31));
        pending_ops.push_back(make_op(MODE_ADD, 0, 31));
        pending_ops.push_back(make_op(MODE_ADD, 63, 0));
        pending_ops.push_back(make_op(MODE_ADD, 5, 7));
        pending_ops.push_back(make_op(MODE_ADD, 6, 7));
        pending_ops.push_back(make_op(MODE_ADD, 7, 7));
        pending_ops.push_back(make_op(MODE_ADD, 8, 0));
        pending_ops.push_back(make_op(MODE_REM, 6, 21));
        pending_ops.push_back(make_op(MODE_REM, 6, 0));
        pending_ops.push_back(make_op(MODE_REM, 8, 0));
        pending_ops.push_back(make_op(MODE_REM, 7, 0));
        pending_ops.push_back(make_op(MODE_REM, 5, 0));
        pending_ops.push_back(make_op(MODE_ADD, 42, 21));
        pending_ops.push_back(make_op(MODE_REM, 0, 0));
        pending_ops.push_back(make_op(MODE_REM, 63, 0));
        pending_ops.push_back(make_op(MODE_REM, 42, 10));
        pending_ops.push_back(make_op(MODE_REM, 63, 0));
        pending_ops.push_back(make_op(MODE_ADD, 0, 0));
        pending_ops.push_back(make_op(MODE_REM, 0, 31));
        wait_drained();

        // Random phases, each run until every answer is back; then the sender pauses.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 14 : 0;
            queue_random(120);
            if (ph == 0)
                holdoff_go = 1'b1;
            wait_drained();
        end
        send_pause = 1'b1;
        repeat (DRAIN_WAIT) @(posedge clk);
        send_pause = 1'b0;

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
